@@ src/euc_btt_pkg.sv @@
// shared types and constants for the bank translation table
// payload structs, operation and status codes, sequencer states; no dependencies
package euc_btt_pkg;

   // operation selector codes
   localparam logic [1:0] FUNC_ASSIGN  = 2'd0;
   localparam logic [1:0] FUNC_LOOKUP  = 2'd1;
   localparam logic [1:0] FUNC_REVERSE = 2'd2;
   localparam logic [1:0] FUNC_NONE    = 2'd3;

   // result status codes
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_MISS = 2'd1;
   localparam logic [1:0] STAT_ERR  = 2'd2;

   // fixed field widths
   localparam int CODE_W = 24;
   localparam int BYTE_W = 8;

   // reverse operations pass codes below this value straight through
   localparam logic [CODE_W-1:0] SHORT_LIMIT = 24'h00ffff;
   // lookup keys always carry the high bit of the top byte
   localparam logic [BYTE_W-1:0] KEY_HIGH = 8'h80;

   typedef struct packed {
      logic [1:0]        func;
      logic [CODE_W-1:0] code;
      logic              strict;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] result;
      logic [1:0]        status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_DONE
   } state_type;

endpackage

@@ src/euc_bank_translation_table.sv @@
// bank translation table top level: sequencer, entry valid bits, top-byte memory
// depends on euc_btt_pkg for payload structs, codes and states
//
// sequencing: short codes, illegal banks and the unused selector go from idle straight
//   to the done state; a reverse read and each searched entry pass through read and compare
// flow: one item at a time; the scan visits each entry with a memory read, then a compare,
//   over up to BANK_COUNT-1 entries through one read port
// reset: synchronous; clears all entry valid bits together, no clearing pass
module euc_bank_translation_table #(
   parameter int BANK_COUNT = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  euc_btt_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output euc_btt_pkg::rsp_type rsp_data
);

   localparam int ENTRIES = BANK_COUNT - 1;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int BANK_W  = 8;
   localparam logic [BANK_W-1:0] BANK_LIMIT = BANK_W'(BANK_COUNT);
   localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(ENTRIES - 1);

   // control state
   euc_btt_pkg::state_type state_ff, state_in;
   logic [ENTRIES-1:0]     used_ff, used_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // item and result registers
   logic [1:0]                     func_ff, func_in;
   logic [euc_btt_pkg::CODE_W-1:0] code_ff, code_in;
   logic                           strict_ff, strict_in;
   logic [euc_btt_pkg::BYTE_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic [euc_btt_pkg::CODE_W-1:0] res_ff, res_in;
   logic [1:0]                     stat_ff, stat_in;
   euc_btt_pkg::rsp_type           rsp_ff, rsp_in;

   // top-byte memory, one read port at idx_ff
   logic [euc_btt_pkg::BYTE_W-1:0] top_mem [ENTRIES];
   logic [euc_btt_pkg::BYTE_W-1:0] rd_ff;
   logic                           mem_we;

   // combinational helpers
   logic [3:0]                     rev_bank;
   logic [BANK_W-1:0]              bank_num;
   logic                           hit;
   logic                           last;
   logic [euc_btt_pkg::BYTE_W-1:0] rev_top;

   assign req_ready = (state_ff == euc_btt_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign rev_bank = req_data.code[19:16];
   assign bank_num = BANK_W'(idx_ff) + BANK_W'(1);
   assign hit      = used_ff[idx_ff] && (rd_ff == key_ff);
   assign last     = (idx_ff == LAST_IDX);
   assign rev_top  = used_ff[idx_ff] ? rd_ff : '0;

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= euc_btt_pkg::ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      code_ff   <= code_in;
      strict_ff <= strict_in;
      key_ff    <= key_in;
      idx_ff    <= idx_in;
      res_ff    <= res_in;
      stat_ff   <= stat_in;
      rsp_ff    <= rsp_in;
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         top_mem[idx_ff] <= key_ff;
      end
      rd_ff <= top_mem[idx_ff];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      func_in      = func_ff;
      code_in      = code_ff;
      strict_in    = strict_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      res_in       = res_ff;
      stat_in      = stat_ff;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;

      unique case (state_ff)
         euc_btt_pkg::ST_IDLE: begin
            if (req_valid) begin
               func_in   = req_data.func;
               code_in   = req_data.code;
               strict_in = req_data.strict;
               idx_in    = '0;
               stat_in   = euc_btt_pkg::STAT_OK;
               res_in    = req_data.code;
               state_in  = euc_btt_pkg::ST_DONE;
               unique case (req_data.func)
                  euc_btt_pkg::FUNC_ASSIGN: begin
                     key_in = req_data.code[23:16];
                     if (req_data.code[23:16] != '0) begin
                        state_in = euc_btt_pkg::ST_READ;
                     end
                  end
                  euc_btt_pkg::FUNC_LOOKUP: begin
                     key_in = req_data.code[21:14] | euc_btt_pkg::KEY_HIGH;
                     if (req_data.code[23:16] != '0) begin
                        state_in = euc_btt_pkg::ST_READ;
                     end
                  end
                  euc_btt_pkg::FUNC_REVERSE: begin
                     if (req_data.code >= euc_btt_pkg::SHORT_LIMIT) begin
                        if (rev_bank == '0 || BANK_W'(rev_bank) >= BANK_LIMIT) begin
                           res_in  = {8'h00, req_data.code[15:0]};
                           stat_in = euc_btt_pkg::STAT_ERR;
                        end else begin
                           idx_in   = IDX_W'(rev_bank - 4'd1);
                           state_in = euc_btt_pkg::ST_READ;
                        end
                     end
                  end
                  default: begin
                     res_in  = '0;
                     stat_in = euc_btt_pkg::STAT_ERR;
                  end
               endcase
            end
         end

         // memory data for idx_ff lands in rd_ff
         euc_btt_pkg::ST_READ: begin
            state_in = euc_btt_pkg::ST_CMP;
         end

         // compare one entry, or finish a reverse read
         euc_btt_pkg::ST_CMP: begin
            state_in = euc_btt_pkg::ST_DONE;
            stat_in  = euc_btt_pkg::STAT_OK;
            case (func_ff)
               euc_btt_pkg::FUNC_ASSIGN: begin
                  res_in = {bank_num[5:0], 2'b00, code_ff[15:0]};
                  if (!used_ff[idx_ff]) begin
                     mem_we           = 1'b1;
                     used_in[idx_ff]  = 1'b1;
                  end else if (!hit) begin
                     if (last) begin
                        res_in  = {BANK_LIMIT[5:0], 2'b00, code_ff[15:0]};
                        stat_in = euc_btt_pkg::STAT_ERR;
                     end else begin
                        idx_in   = idx_ff + IDX_W'(1);
                        state_in = euc_btt_pkg::ST_READ;
                     end
                  end
               end
               euc_btt_pkg::FUNC_LOOKUP: begin
                  if (hit) begin
                     res_in = {bank_num, 2'b00, code_ff[13:0]};
                  end else if (last) begin
                     if (strict_ff) begin
                        res_in  = {BANK_LIMIT, 2'b00, code_ff[13:0]};
                        stat_in = euc_btt_pkg::STAT_ERR;
                     end else begin
                        res_in  = '0;
                        stat_in = euc_btt_pkg::STAT_MISS;
                     end
                  end else begin
                     idx_in   = idx_ff + IDX_W'(1);
                     state_in = euc_btt_pkg::ST_READ;
                  end
               end
               default: begin
                  res_in = {8'h00, code_ff[15:0]} | {3'b000, rev_top[6:0], 14'h0000};
               end
            endcase
         end

         // hand the result to the output register once it is free
         euc_btt_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.result = res_ff;
               rsp_in.status = stat_ff;
               rsp_valid_in  = 1'b1;
               state_in      = euc_btt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = euc_btt_pkg::ST_IDLE;
         end
      endcase
   end

   // an accepted item always starts work
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != euc_btt_pkg::ST_IDLE)
      else $error("accepted item did not start");

   // entries are allocated in order, so valid bits form a prefix
   assert property (@(posedge clock) disable iff (reset)
      ((used_ff + ENTRIES'(1)) & used_ff) == '0)
      else $error("valid bits are not a prefix");

   // memory is written only when allocating a free entry during a compare
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == euc_btt_pkg::ST_CMP && !used_ff[idx_ff]
                 && func_ff == euc_btt_pkg::FUNC_ASSIGN)
      else $error("unexpected table write");

   // an allocated entry is marked valid
   assert property (@(posedge clock) disable iff (reset)
      mem_we |=> used_ff[$past(idx_ff)])
      else $error("allocated entry not marked valid");

   // a result is loaded only from the done state
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(state_ff) == euc_btt_pkg::ST_DONE)
      else $error("result raised outside done state");

endmodule

@@ verif/euc_bank_translation_table_tb.sv @@
// self-checking testbench for the bank translation table
// depends on euc_btt_pkg and euc_bank_translation_table; directed table, then random traffic
module euc_bank_translation_table_tb;

   localparam int BANKS           = 8;
   localparam int ENTRY_CNT       = BANKS - 1;
   localparam int RESET_CYCLES    = 6;
   localparam int RAND_ITEMS      = 1825;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 40;
   localparam int WATCHDOG_LIMIT  = 4000;

   // one row of the directed table; fixed rows carry a hand-typed response
   typedef struct packed {
      euc_btt_pkg::req_type item;
      logic                 fixed;
      euc_btt_pkg::rsp_type want;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   euc_btt_pkg::req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   euc_btt_pkg::rsp_type rsp_data;

   // shadow copy of the bank table
   logic       bank_used [ENTRY_CNT];
   logic [7:0] bank_top  [ENTRY_CNT];

   euc_btt_pkg::rsp_type pending_xlat_q [$];
   stim_row_type         directed_q [$];
   euc_btt_pkg::rsp_type rsp_want;
   int                   fail_cnt;
   int                   idle_cycles;
   int                   stall_left;
   bit                   calm;
   bit                   hold_rsp;

   euc_bank_translation_table #(
      .BANK_COUNT(BANKS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // expected translation for one request, updating the shadow table
   function automatic euc_btt_pkg::rsp_type translate_code(input euc_btt_pkg::req_type item);
      euc_btt_pkg::rsp_type r;
      logic [7:0]           top;
      logic [7:0]           key;
      logic [3:0]           bank;
      int                   slot;
      r.result = '0;
      r.status = euc_btt_pkg::STAT_ERR;
      slot     = -1;
      case (item.func)
         euc_btt_pkg::FUNC_ASSIGN: begin
            top = item.code[23:16];
            if (top == 8'h00) begin
               r.result = item.code;
               r.status = euc_btt_pkg::STAT_OK;
            end else begin
               // first entry that holds the byte or is still free
               for (int i = 0; i < ENTRY_CNT; i++) begin
                  if (slot < 0 && (!bank_used[i] || bank_top[i] == top)) slot = i;
               end
               if (slot < 0) begin
                  r.result = {6'(BANKS), 2'b00, item.code[15:0]};
               end else begin
                  bank_used[slot] = 1'b1;
                  bank_top[slot]  = top;
                  r.result = {6'(slot + 1), 2'b00, item.code[15:0]};
                  r.status = euc_btt_pkg::STAT_OK;
               end
            end
         end
         euc_btt_pkg::FUNC_LOOKUP: begin
            if (item.code[23:16] == 8'h00) begin
               r.result = item.code;
               r.status = euc_btt_pkg::STAT_OK;
            end else begin
               key = item.code[21:14] | euc_btt_pkg::KEY_HIGH;
               for (int i = 0; i < ENTRY_CNT; i++) begin
                  if (slot < 0 && bank_used[i] && bank_top[i] == key) slot = i;
               end
               if (slot >= 0) begin
                  r.result = {8'(slot + 1), 2'b00, item.code[13:0]};
                  r.status = euc_btt_pkg::STAT_OK;
               end else if (item.strict) begin
                  r.result = {8'(BANKS), 2'b00, item.code[13:0]};
               end else begin
                  r.status = euc_btt_pkg::STAT_MISS;
               end
            end
         end
         euc_btt_pkg::FUNC_REVERSE: begin
            bank = item.code[19:16];
            if (item.code < euc_btt_pkg::SHORT_LIMIT) begin
               r.result = item.code;
               r.status = euc_btt_pkg::STAT_OK;
            end else if (bank == 4'd0 || int'(bank) >= BANKS) begin
               r.result = {8'h00, item.code[15:0]};
            end else begin
               top = bank_used[bank - 1] ? bank_top[bank - 1] : 8'h00;
               r.result = {8'h00, item.code[15:0]} | {3'b000, top[6:0], 14'h0000};
               r.status = euc_btt_pkg::STAT_OK;
            end
         end
         default: begin
            r.result = '0;
            r.status = euc_btt_pkg::STAT_ERR;
         end
      endcase
      return r;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int p;
      p = $urandom_range(99);
      if (calm) return 0;
      if (p < 55) return 0;
      if (p < 90) return $urandom_range(3, 1);
      if (p < 98) return $urandom_range(10, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic stim_row_type dir_row(input logic [1:0] func, input logic [23:0] code,
                                            input logic strict, input logic fixed,
                                            input logic [23:0] result, input logic [1:0] status);
      stim_row_type row;
      row.item.func   = func;
      row.item.code   = code;
      row.item.strict = strict;
      row.fixed       = fixed;
      row.want.result = result;
      row.want.status = status;
      return row;
   endfunction

   // random request, mostly aimed at live table entries
   function automatic euc_btt_pkg::req_type random_req();
      euc_btt_pkg::req_type item;
      int                   p;
      int                   ent;
      p           = $urandom_range(99);
      ent         = $urandom_range(ENTRY_CNT - 1);
      item.code   = 24'($urandom);
      item.strict = 1'($urandom_range(1));
      if (p < 25) begin
         item.func           = euc_btt_pkg::FUNC_ASSIGN;
         item.code[23:16]    = bank_top[ent];
      end else if (p < 35) begin
         item.func = euc_btt_pkg::FUNC_ASSIGN;
         if ($urandom_range(7) == 0) item.code[23:16] = 8'h00;
      end else if (p < 60) begin
         // lookup key built from a stored top byte; its high bit is forced anyway
         item.func        = euc_btt_pkg::FUNC_LOOKUP;
         item.code[21:14] = bank_top[ent];
         if ($urandom_range(1) == 1) item.code[21] = 1'b0;
      end else if (p < 68) begin
         item.func = euc_btt_pkg::FUNC_LOOKUP;
         if ($urandom_range(7) == 0) item.code[23:16] = 8'h00;
      end else if (p < 90) begin
         item.func        = euc_btt_pkg::FUNC_REVERSE;
         item.code[19:16] = 4'($urandom_range(ENTRY_CNT, 1));
      end else if (p < 96) begin
         item.func = euc_btt_pkg::FUNC_REVERSE;
         if ($urandom_range(3) == 0) item.code = 24'($urandom_range(24'h01ffff));
      end else begin
         item.func = 2'($urandom_range(3));
      end
      return item;
   endfunction

   // offer one request, record its expected response once transferred
   task automatic send_item(input euc_btt_pkg::req_type item, input logic fixed,
                            input euc_btt_pkg::rsp_type want, input bit wait_idle);
      euc_btt_pkg::rsp_type predicted;
      int                   gap;
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = translate_code(item);
      pending_xlat_q.push_back(fixed ? want : predicted);
      @(negedge clock);
      gap = pick_gap();
      if (wait_idle && gap == 0) gap = 1;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
         while (wait_idle && pending_xlat_q.size() != 0) @(negedge clock);
      end
   endtask

   // response side ready pattern, with one long hold on request
   initial begin
      rsp_ready  = 1'b0;
      stall_left = 0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            for (int n = 0; n < RSP_HOLD_CYCLES; n++) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // response check and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_xlat_q.size() == 0) begin
               $error("unexpected response: result %h status %0d",
                      rsp_data.result, rsp_data.status);
               fail_cnt++;
            end else begin
               rsp_want = pending_xlat_q.pop_front();
               if (rsp_data.result !== rsp_want.result) begin
                  $error("result: expected %h, actual %h", rsp_want.result, rsp_data.result);
                  fail_cnt++;
               end
               if (rsp_data.status !== rsp_want.status) begin
                  $error("status: expected %0d, actual %0d", rsp_want.status, rsp_data.status);
                  fail_cnt++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("euc_bank_translation_table test failed");
            $finish;
         end
      end
   end

   initial begin
      euc_btt_pkg::req_type item;
      euc_btt_pkg::rsp_type none;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      fail_cnt    = 0;
      idle_cycles = 0;
      calm        = 1'b0;
      hold_rsp    = 1'b0;
      none        = '0;
      for (int i = 0; i < ENTRY_CNT; i++) begin
         bank_used[i] = 1'b0;
         bank_top[i]  = 8'h00;
      end

      // empty table: reverse of an unused bank, misses, short codes, illegal banks, the unused selector
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_REVERSE, 24'h011234, 1'b0, 1'b1,
                                   24'h001234, euc_btt_pkg::STAT_OK));
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_LOOKUP,  24'h820000, 1'b0, 1'b1,
                                   24'h000000, euc_btt_pkg::STAT_MISS));
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_LOOKUP,  24'hffffff, 1'b1, 1'b1,
                                   24'h083fff, euc_btt_pkg::STAT_ERR));
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_ASSIGN,  24'h00abcd, 1'b1, 1'b1,
                                   24'h00abcd, euc_btt_pkg::STAT_OK));
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_LOOKUP,  24'h00ffff, 1'b1, 1'b1,
                                   24'h00ffff, euc_btt_pkg::STAT_OK));
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_REVERSE, 24'h00fffe, 1'b0, 1'b1,
                                   24'h00fffe, euc_btt_pkg::STAT_OK));
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_REVERSE, 24'h00ffff, 1'b0, 1'b1,
                                   24'h00ffff, euc_btt_pkg::STAT_ERR));
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_REVERSE, 24'h080000, 1'b0, 1'b1,
                                   24'h000000, euc_btt_pkg::STAT_ERR));
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_REVERSE, 24'hff1234, 1'b1, 1'b1,
                                   24'h001234, euc_btt_pkg::STAT_ERR));
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_NONE,    24'hffffff, 1'b1, 1'b1,
                                   24'h000000, euc_btt_pkg::STAT_ERR));
      // fill all entries, then overflow
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_ASSIGN,  24'hff0000, 1'b0, 1'b1,
                                   24'h040000, euc_btt_pkg::STAT_OK));
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_ASSIGN,  24'hffffff, 1'b1, 1'b1,
                                   24'h04ffff, euc_btt_pkg::STAT_OK));
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_ASSIGN,  24'h01ffff, 1'b0, 1'b0,
                                   '0, euc_btt_pkg::STAT_OK));
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_ASSIGN,  24'h805555, 1'b1, 1'b0,
                                   '0, euc_btt_pkg::STAT_OK));
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_ASSIGN,  24'h7f0001, 1'b0, 1'b0,
                                   '0, euc_btt_pkg::STAT_OK));
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_REVERSE, 24'h06abcd, 1'b0, 1'b0,
                                   '0, euc_btt_pkg::STAT_OK));
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_ASSIGN,  24'hc3aaaa, 1'b0, 1'b0,
                                   '0, euc_btt_pkg::STAT_OK));
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_ASSIGN,  24'ha51234, 1'b1, 1'b0,
                                   '0, euc_btt_pkg::STAT_OK));
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_ASSIGN,  24'h90fedc, 1'b0, 1'b0,
                                   '0, euc_btt_pkg::STAT_OK));
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_ASSIGN,  24'h123456, 1'b0, 1'b1,
                                   24'h203456, euc_btt_pkg::STAT_ERR));
      // hits with and without the forced key bit, strict miss, reverse of full entries
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_LOOKUP,  24'h3fffff, 1'b0, 1'b0,
                                   '0, euc_btt_pkg::STAT_OK));
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_LOOKUP,  24'hc00123, 1'b1, 1'b0,
                                   '0, euc_btt_pkg::STAT_OK));
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_LOOKUP,  24'h404000, 1'b1, 1'b0,
                                   '0, euc_btt_pkg::STAT_OK));
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_REVERSE, 24'hf4ffff, 1'b0, 1'b0,
                                   '0, euc_btt_pkg::STAT_OK));
      directed_q.push_back(dir_row(euc_btt_pkg::FUNC_REVERSE, 24'h07ffff, 1'b0, 1'b0,
                                   '0, euc_btt_pkg::STAT_OK));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_q[i]) begin
         send_item(directed_q[i].item, directed_q[i].fixed, directed_q[i].want, 1'b0);
      end

      // random traffic with windows free of gaps and stalls, one long response hold, two full drains
      for (int n = 0; n < RAND_ITEMS; n++) begin
         calm = (n >= 400 && n < 600) || (n >= 1200 && n < 1300);
         if (n == 800) hold_rsp = 1'b1;
         item = random_req();
         send_item(item, 1'b0, none, (n == 1000) || (n == RAND_ITEMS - 1));
      end

      while (pending_xlat_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_cnt == 0) begin
         $display("euc_bank_translation_table test passed");
      end else begin
         $display("euc_bank_translation_table test failed");
      end
      $finish;
   end

endmodule
